@@ hw/rtl/mwm_pkg.sv @@
// Shared constants, types and helper functions for the membrane wave mesh.
`default_nettype none
package mwm_pkg;

  localparam int GRID_MAX   = 16;
  localparam int GRID_BITS  = 4;
  localparam int CELL_BITS  = 2 * GRID_BITS;
  localparam int CELLS      = GRID_MAX * GRID_MAX;
  localparam int MESH_W     = 24;
  localparam int PIPE_DEPTH = 4;
  localparam int DRAIN_BITS = 2;

  localparam logic signed [MESH_W-1:0] MESH_MAX = 24'sh7FFFFF;
  localparam logic signed [MESH_W-1:0] MESH_MIN = 24'sh800000;
  localparam logic signed [21:0]       ONE_Q20  = 22'sh100000;

  localparam logic [14:0] C2_LIMIT   = 15'd32702;
  localparam logic [4:0]  GRID_RESET = 5'd10;
  localparam logic [4:0]  GRID_LOW   = 5'd3;
  localparam logic [4:0]  GRID_HIGH  = 5'd16;
  localparam logic [23:0] DAMP_RESET = 24'd16768827;
  localparam logic [3:0]  PICK_RESET = 4'd4;
  localparam logic [15:0] VOL_RESET  = 16'd32768;
  localparam logic [11:0] BUMP_LEN   = 12'd34;

  typedef enum logic [2:0] {
    REG_GRID, REG_SHAPE, REG_EDGE, REG_DAMP, REG_PCOL, REG_PROW, REG_VOL
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_DRAIN, ST_MUL, ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [MESH_W-1:0] c;
    logic signed [MESH_W-1:0] b;
    logic signed [MESH_W-1:0] left;
    logic signed [MESH_W-1:0] right;
    logic signed [MESH_W-1:0] up;
    logic signed [MESH_W-1:0] down;
  } taps_t;

  typedef struct packed {
    logic [4:0]  grid;
    logic        circle;
    logic        free;
    logic [23:0] damping;
    logic [14:0] c2;
  } prm_t;

  typedef struct packed {
    logic                     vld;
    logic [CELL_BITS-1:0]     idx;
    logic signed [MESH_W-1:0] val;
  } res_t;

  function automatic logic inside_cell(input logic signed [5:0] x, input logic signed [5:0] y,
                                       input logic [4:0] g, input logic circ);
    logic signed [15:0] gs;
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               in_grid;
    gs = $signed({11'd0, g});
    xs = $signed({{10{x[5]}}, x});
    ys = $signed({{10{y[5]}}, y});
    dx = (xs <<< 1) - gs + 16'sd1;
    dy = (ys <<< 1) - gs + 16'sd1;
    in_grid = (xs >= 16'sd0) && (ys >= 16'sd0) && (xs < gs) && (ys < gs);
    return in_grid && (!circ || (dx * dx + dy * dy <= gs * gs));
  endfunction

  // exp(-d/2.88) in Q1.16 by squared distance
  function automatic logic [16:0] bump_lut(input logic [5:0] d);
    logic [16:0] t;
    case (d)
      6'd0:  t = 17'd65536;
      6'd1:  t = 17'd46311;
      6'd2:  t = 17'd32726;
      6'd3:  t = 17'd23125;
      6'd4:  t = 17'd16341;
      6'd5:  t = 17'd11548;
      6'd6:  t = 17'd8160;
      6'd7:  t = 17'd5766;
      6'd8:  t = 17'd4075;
      6'd9:  t = 17'd2879;
      6'd10: t = 17'd2035;
      6'd11: t = 17'd1438;
      6'd12: t = 17'd1016;
      6'd13: t = 17'd718;
      6'd14: t = 17'd507;
      6'd15: t = 17'd359;
      6'd16: t = 17'd253;
      6'd17: t = 17'd179;
      6'd18: t = 17'd127;
      6'd19: t = 17'd89;
      6'd20: t = 17'd63;
      6'd21: t = 17'd45;
      6'd22: t = 17'd32;
      6'd23: t = 17'd22;
      6'd24: t = 17'd16;
      6'd25: t = 17'd11;
      6'd26: t = 17'd8;
      6'd27: t = 17'd6;
      6'd28: t = 17'd4;
      6'd29: t = 17'd3;
      6'd30: t = 17'd2;
      6'd31: t = 17'd1;
      6'd32: t = 17'd1;
      6'd33: t = 17'd1;
      default: t = 17'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mwm_if.sv @@
// Handshake channels of the membrane wave mesh: items in, samples out, register writes.
`default_nettype none
interface mwm_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] amplitude;
  logic [3:0]  strike_col;
  logic [3:0]  strike_row;
  logic [14:0] courant;
  logic [15:0] env_gain;
  modport source(output valid, action, amplitude, strike_col, strike_row, courant, env_gain,
                 input ready);
  modport sink(input valid, action, amplitude, strike_col, strike_row, courant, env_gain,
               output ready);
endinterface

interface mwm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source(output valid, sample, input ready);
  modport sink(input valid, sample, output ready);
endinterface

interface mwm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/membrane_wave_mesh_step.sv @@
// Membrane wave mesh: a 256-cell ring of mesh cells swept by one leapfrog update unit.
// Use: items arrive on req (valid/ready), one sample word leaves on rsp per tick item,
// registers are written on cfg, which is always ready. Write registers only while idle.
// A tick item circulates the whole ring once through the update unit, one cell per cycle:
// it is accepted, sweeps the ring, drains the update pipeline, multiplies the pickup
// value and loads the output register.
// A strike item sweeps the ring once writing the bump.
// The ring length and the four-stage update pipeline set the length of a tick.
// req.ready is high only while the block is idle; the next item is taken while the
// previous sample still waits in the output register.
// If the receiver stalls, the finished sample holds in the output register and a
// later tick waits before loading its own sample.
// Reset (rst, synchronous) zeros both mesh values of every cell, the held Courant
// number and the output valid flag, and loads the register defaults.
// Writing grid_size zeros the whole mesh at once.
`default_nettype none
module membrane_wave_mesh_step (
  input  logic         clk,
  input  logic         rst,
  mwm_req_if.sink      req,
  mwm_rsp_if.source    rsp,
  mwm_cfg_if.sink      cfg
);

  localparam int CELLS = mwm_pkg::CELLS;
  localparam int MW    = mwm_pkg::MESH_W;
  localparam int CB    = mwm_pkg::CELL_BITS;
  localparam int GB    = mwm_pkg::GRID_BITS;

  logic [4:0]  grid;
  logic        circle;
  logic        free;
  logic [23:0] damping;
  logic [3:0]  pcol;
  logic [3:0]  prow;
  logic [15:0] volume;
  logic [14:0] c2_held;

  mwm_pkg::state_t state, state_next;
  logic            req_ready;
  logic            accept;
  logic            shift;
  logic            emit;

  logic [CB-1:0]                    k;
  logic [mwm_pkg::DRAIN_BITS-1:0]   drain_cnt;
  logic                             is_tick;
  logic [15:0]                      amp_q;
  logic [3:0]                       sx_q;
  logic [3:0]                       sy_q;
  logic [31:0]                      ve_q;
  logic signed [MW-1:0]             pick;
  logic signed [54:0]               prod2;
  logic                             out_valid;
  logic signed [15:0]               out_sample;

  logic signed [MW-1:0] now_q [CELLS];
  logic signed [MW-1:0] bef_q [CELLS];
  logic signed [MW-1:0] now_d [CELLS];
  logic signed [MW-1:0] bef_d [CELLS];
  logic                 cell_en [CELLS];
  logic                 grid_wr;

  mwm_pkg::taps_t taps;
  mwm_pkg::prm_t  prm;
  mwm_pkg::res_t  res;

  logic [4:0]  gm2;
  logic [4:0]  gm1;
  logic [3:0]  sx_c;
  logic [3:0]  sy_c;
  logic [3:0]  px;
  logic [3:0]  py;
  logic [CB-1:0] pidx;

  logic signed [5:0]  bx, by, ddx, ddy;
  logic signed [11:0] sqx, sqy, dd;
  logic               bump_in;
  logic [32:0]        bprod;
  logic [32:0]        brnd;
  logic signed [MW-1:0] bump;

  logic signed [21:0] p22;
  logic signed [54:0] rnd3;
  logic signed [54:0] sh3;
  logic signed [15:0] sat3;

  // configuration
  assign cfg.ready = 1'b1;
  assign grid_wr   = cfg.valid && (cfg.index == mwm_pkg::REG_GRID);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid    <= mwm_pkg::GRID_RESET;
      circle  <= 1'b0;
      free    <= 1'b0;
      damping <= mwm_pkg::DAMP_RESET;
      pcol    <= mwm_pkg::PICK_RESET;
      prow    <= mwm_pkg::PICK_RESET;
      volume  <= mwm_pkg::VOL_RESET;
    end else if (cfg.valid) begin
      case (mwm_pkg::cfg_reg_t'(cfg.index))
        mwm_pkg::REG_GRID: begin
          if (cfg.data[4:0] < mwm_pkg::GRID_LOW) grid <= mwm_pkg::GRID_LOW;
          else if (cfg.data[4:0] > mwm_pkg::GRID_HIGH) grid <= mwm_pkg::GRID_HIGH;
          else grid <= cfg.data[4:0];
        end
        mwm_pkg::REG_SHAPE: circle  <= cfg.data[0];
        mwm_pkg::REG_EDGE:  free    <= cfg.data[0];
        mwm_pkg::REG_DAMP:  damping <= cfg.data;
        mwm_pkg::REG_PCOL:  pcol    <= cfg.data[3:0];
        mwm_pkg::REG_PROW:  prow    <= cfg.data[3:0];
        mwm_pkg::REG_VOL:   volume  <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) state <= mwm_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    emit       = 1'b0;
    case (state)
      mwm_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid && (!req.action || req.amplitude != 16'd0))
          state_next = mwm_pkg::ST_SWEEP;
      end
      mwm_pkg::ST_SWEEP: begin
        if (k == CB'(CELLS - 1))
          state_next = is_tick ? mwm_pkg::ST_DRAIN : mwm_pkg::ST_IDLE;
      end
      mwm_pkg::ST_DRAIN: begin
        if (drain_cnt == mwm_pkg::DRAIN_BITS'(mwm_pkg::PIPE_DEPTH - 1))
          state_next = mwm_pkg::ST_MUL;
      end
      mwm_pkg::ST_MUL: state_next = mwm_pkg::ST_EMIT;
      mwm_pkg::ST_EMIT: begin
        if (!out_valid || rsp.ready) begin
          emit       = 1'b1;
          state_next = mwm_pkg::ST_IDLE;
        end
      end
      default: state_next = mwm_pkg::ST_IDLE;
    endcase
  end

  assign req.ready = req_ready;
  assign accept    = req.valid && req_ready;
  assign shift     = (state == mwm_pkg::ST_SWEEP);

  // clamps of strike and pickup positions
  always_comb begin
    gm2  = grid - 5'd2;
    gm1  = grid - 5'd1;
    if (req.strike_col == 4'd0) sx_c = 4'd1;
    else if ({1'b0, req.strike_col} > gm2) sx_c = gm2[3:0];
    else sx_c = req.strike_col;
    if (req.strike_row == 4'd0) sy_c = 4'd1;
    else if ({1'b0, req.strike_row} > gm2) sy_c = gm2[3:0];
    else sy_c = req.strike_row;
    px   = ({1'b0, pcol} > gm1) ? gm1[3:0] : pcol;
    py   = ({1'b0, prow} > gm1) ? gm1[3:0] : prow;
    pidx = {py, px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      drain_cnt <= '0;
      is_tick   <= 1'b0;
      c2_held   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        k         <= '0;
        drain_cnt <= '0;
        is_tick   <= !req.action;
        if (req.action && req.amplitude != 16'd0)
          c2_held <= (req.courant > mwm_pkg::C2_LIMIT) ? mwm_pkg::C2_LIMIT : req.courant;
      end
      if (shift) k <= k + CB'(1);
      if (state == mwm_pkg::ST_DRAIN) drain_cnt <= drain_cnt + mwm_pkg::DRAIN_BITS'(1);
      if (emit) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      amp_q <= req.amplitude;
      sx_q  <= sx_c;
      sy_q  <= sy_c;
      ve_q  <= volume * req.env_gain;
    end
    if (res.vld && res.idx == pidx) pick <= res.val;
    if (state == mwm_pkg::ST_MUL) prod2 <= p22 * $signed({1'b0, ve_q});
    if (emit) out_sample <= sat3;
  end

  // strike bump for the cell at the ring head
  always_comb begin
    bx      = $signed({2'b00, k[GB-1:0]});
    by      = $signed({2'b00, k[CB-1:GB]});
    ddx     = bx - $signed({2'b00, sx_q});
    ddy     = by - $signed({2'b00, sy_q});
    sqx     = ddx * ddx;
    sqy     = ddy * ddy;
    dd      = sqx + sqy;
    bump_in = mwm_pkg::inside_cell(bx, by, grid, circle) &&
              (dd < $signed(mwm_pkg::BUMP_LEN));
    bprod   = amp_q * mwm_pkg::bump_lut(dd[5:0]);
    brnd    = (bprod + 33'd2048) >> 12;
    bump    = bump_in ? $signed({3'b000, brnd[20:0]}) : '0;
  end

  // output scaling
  always_comb begin
    if (pick > $signed(mwm_pkg::ONE_Q20)) p22 = mwm_pkg::ONE_Q20;
    else if (pick < -$signed(mwm_pkg::ONE_Q20)) p22 = -mwm_pkg::ONE_Q20;
    else p22 = pick[21:0];
    rnd3 = prod2 + (55'sd1 <<< 36);
    sh3  = rnd3 >>> 37;
    if (sh3 > 55'sd32767) sat3 = 16'sh7FFF;
    else if (sh3 < -55'sd32768) sat3 = 16'sh8000;
    else sat3 = sh3[15:0];
  end

  assign rsp.valid  = out_valid;
  assign rsp.sample = out_sample;

  // ring feed: each cell takes its neighbor's word while sweeping
  always_comb begin
    for (int i = 1; i < CELLS; i++) begin
      now_d[i]   = now_q[i-1];
      bef_d[i]   = bef_q[i-1];
      cell_en[i] = shift;
    end
    cell_en[0] = shift;
    if (is_tick) begin
      now_d[0] = now_q[CELLS-1];
      bef_d[0] = now_q[CELLS-1];
    end else begin
      now_d[0] = bump;
      bef_d[0] = '0;
    end
    if (res.vld) now_d[mwm_pkg::PIPE_DEPTH] = res.val;
    // drop the last results into the cells that stopped short of the write-back point
    for (int i = 0; i < mwm_pkg::PIPE_DEPTH; i++) begin
      if (state == mwm_pkg::ST_DRAIN &&
          drain_cnt == mwm_pkg::DRAIN_BITS'(mwm_pkg::PIPE_DEPTH - 1 - i)) begin
        cell_en[i] = 1'b1;
        now_d[i]   = res.val;
        bef_d[i]   = bef_q[i];
      end
    end
  end

  for (genvar gi = 0; gi < CELLS; gi++) begin : g_ring
    mwm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .clr   (grid_wr),
      .en    (cell_en[gi]),
      .now_d (now_d[gi]),
      .bef_d (bef_d[gi]),
      .now_q (now_q[gi]),
      .bef_q (bef_q[gi])
    );
  end

  assign taps.c     = now_q[CELLS-1];
  assign taps.b     = bef_q[CELLS-1];
  assign taps.left  = bef_q[0];
  assign taps.up    = bef_q[mwm_pkg::GRID_MAX-1];
  assign taps.right = now_q[CELLS-2];
  assign taps.down  = now_q[CELLS-1-mwm_pkg::GRID_MAX];

  assign prm.grid    = grid;
  assign prm.circle  = circle;
  assign prm.free    = free;
  assign prm.damping = damping;
  assign prm.c2      = c2_held;

  mwm_update u_update (
    .clk  (clk),
    .rst  (rst),
    .taps (taps),
    .prm  (prm),
    .k    (k),
    .go   (shift && is_tick),
    .res  (res)
  );

endmodule
`default_nettype wire

@@ hw/rtl/mwm_cell.sv @@
// One mesh cell of the circulating ring: current and previous value.
`default_nettype none
module mwm_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clr,
  input  logic                              en,
  input  logic signed [mwm_pkg::MESH_W-1:0] now_d,
  input  logic signed [mwm_pkg::MESH_W-1:0] bef_d,
  output logic signed [mwm_pkg::MESH_W-1:0] now_q,
  output logic signed [mwm_pkg::MESH_W-1:0] bef_q
);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      now_q <= '0;
      bef_q <= '0;
    end else if (en) begin
      now_q <= now_d;
      bef_q <= bef_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mwm_update.sv @@
// Four-stage leapfrog update of the cell passing the ring head.
`default_nettype none
module mwm_update (
  input  logic                             clk,
  input  logic                             rst,
  input  mwm_pkg::taps_t                   taps,
  input  mwm_pkg::prm_t                    prm,
  input  logic [mwm_pkg::CELL_BITS-1:0]    k,
  input  logic                             go,
  output mwm_pkg::res_t                    res
);

  logic signed [5:0]  x;
  logic signed [5:0]  y;
  logic signed [5:0]  gm1;
  logic               act;
  logic signed [23:0] nl;
  logic signed [23:0] nr;
  logic signed [23:0] nu;
  logic signed [23:0] nd;
  logic signed [27:0] lap;
  logic signed [25:0] a;

  logic                          s1_vld, s2_vld, s3_vld, s4_vld;
  logic                          s1_act, s2_act, s3_act, s4_act;
  logic [mwm_pkg::CELL_BITS-1:0] s1_idx, s2_idx, s3_idx, s4_idx;
  logic signed [27:0]            s1_lap;
  logic signed [25:0]            s1_a, s2_a;
  logic signed [43:0]            s2_m;
  logic signed [27:0]            s3_v;
  logic signed [52:0]            s4_p;

  logic signed [43:0] rnd1;
  logic signed [52:0] rnd2;
  logic signed [52:0] sh2;
  logic signed [23:0] sat2;

  function automatic logic signed [23:0] nb(input logic ok, input logic signed [23:0] v,
                                            input logic free, input logic signed [23:0] own);
    logic signed [23:0] r;
    if (ok) r = v;
    else if (free) r = own;
    else r = '0;
    return r;
  endfunction

  always_comb begin
    x   = $signed({2'b00, k[mwm_pkg::GRID_BITS-1:0]});
    y   = $signed({2'b00, k[mwm_pkg::CELL_BITS-1:mwm_pkg::GRID_BITS]});
    gm1 = $signed({1'b0, prm.grid}) - 6'sd1;
    act = mwm_pkg::inside_cell(x, y, prm.grid, prm.circle) &&
          (prm.free || !(x == 6'sd0 || y == 6'sd0 || x == gm1 || y == gm1));
    nl  = nb(mwm_pkg::inside_cell(x - 6'sd1, y, prm.grid, prm.circle), taps.left,
             prm.free, taps.c);
    nr  = nb(mwm_pkg::inside_cell(x + 6'sd1, y, prm.grid, prm.circle), taps.right,
             prm.free, taps.c);
    nu  = nb(mwm_pkg::inside_cell(x, y - 6'sd1, prm.grid, prm.circle), taps.up,
             prm.free, taps.c);
    nd  = nb(mwm_pkg::inside_cell(x, y + 6'sd1, prm.grid, prm.circle), taps.down,
             prm.free, taps.c);
    lap = nl + nr + nu + nd - (taps.c <<< 2);
    a   = (taps.c <<< 1) - taps.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      s1_vld <= go;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
  end

  always_comb begin
    rnd1 = s2_m + 44'sd32768;
    rnd2 = s4_p + (53'sd1 <<< 23);
    sh2  = rnd2 >>> 24;
    if (sh2 > mwm_pkg::MESH_MAX) sat2 = mwm_pkg::MESH_MAX;
    else if (sh2 < mwm_pkg::MESH_MIN) sat2 = mwm_pkg::MESH_MIN;
    else sat2 = sh2[23:0];
  end

  always_ff @(posedge clk) begin
    s1_act <= act;
    s1_idx <= k;
    s1_lap <= lap;
    s1_a   <= a;
    s2_act <= s1_act;
    s2_idx <= s1_idx;
    s2_a   <= s1_a;
    s2_m   <= s1_lap * $signed({1'b0, prm.c2});
    s3_act <= s2_act;
    s3_idx <= s2_idx;
    s3_v   <= 28'((rnd1 >>> 16) + s2_a);
    s4_act <= s3_act;
    s4_idx <= s3_idx;
    s4_p   <= s3_v * $signed({1'b0, prm.damping});
  end

  assign res.vld = s4_vld;
  assign res.idx = s4_idx;
  assign res.val = s4_act ? sat2 : '0;

endmodule
`default_nettype wire
